[hw/rtl/dau_pkg.sv]
// Shared types, constants and helper functions for the angle-to-unit-vector block.
package dau_pkg;

  localparam int DIM     = 4;          // output dimensions
  localparam int NA      = DIM - 1;    // angle lanes
  localparam int NSTEP   = 7;          // Horner steps (cosine series depth)

  localparam logic [31:0] Q31_ONE    = 32'h8000_0000;
  localparam logic [31:0] PIHALF_Q31 = 32'hC90F_DAA2;
  localparam logic [30:0] Q_ONE      = 31'h4000_0000;

  // register index of dims_used
  localparam logic REG_DIMS_USED = 1'b0;

  typedef enum logic [1:0] {
    LK_NORM = 2'd0,   // sine and cosine from the series
    LK_SIN1 = 2'd1,   // sine one, cosine zero (right edge or unused angle)
    LK_COS1 = 2'd2    // sine zero, cosine one (left edge)
  } lane_kind_t;

  typedef struct packed {
    logic signed [31:0] angle_id_2;
    logic signed [31:0] angle_id_1;
    logic signed [31:0] angle_id_0;
  } in_t;

  typedef struct packed {
    logic        bad_id;
    logic [30:0] uv_3;
    logic [30:0] uv_2;
    logic [30:0] uv_1;
    logic [30:0] uv_0;
  } res_t;

  // data riding along the Horner chain
  typedef struct packed {
    logic [NA-1:0][31:0]  x;
    logic [NA-1:0]        swap;
    lane_kind_t [NA-1:0]  kind;
    logic                 bad;
  } side_t;

  // data moving along the product chain
  typedef struct packed {
    logic [30:0]          im;
    logic [NA-1:0][30:0]  s;
    logic [NA-1:0][30:0]  c;
    logic [DIM-1:0][30:0] uv;
    logic                 bad;
  } prod_t;

  // sine series denominator used by Horner step 'step'; zero means pass through
  function automatic logic [31:0] sin_den(input int step);
    logic [31:0] r;
    case (step)
      1:       r = 32'd156;
      2:       r = 32'd110;
      3:       r = 32'd72;
      4:       r = 32'd42;
      5:       r = 32'd20;
      6:       r = 32'd6;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] cos_den(input int step);
    logic [31:0] r;
    case (step)
      0:       r = 32'd182;
      1:       r = 32'd132;
      2:       r = 32'd90;
      3:       r = 32'd56;
      4:       r = 32'd30;
      5:       r = 32'd12;
      6:       r = 32'd2;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

  // Q1.30 product, rounded half up
  function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + (62'd1 << 29);
    return p[60:30];
  endfunction

endpackage

[hw/rtl/dau_horner_cell.sv]
// One Horner step of the sine and cosine series for all angle lanes, three stages deep.
module dau_horner_cell #(
  parameter int STEP = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic [dau_pkg::NA-1:0][31:0]  in_x2,
  input  logic [dau_pkg::NA-1:0][31:0]  in_ts,
  input  logic [dau_pkg::NA-1:0][31:0]  in_tc,
  input  dau_pkg::side_t                in_side,
  output logic                          out_vld,
  output logic [dau_pkg::NA-1:0][31:0]  out_x2,
  output logic [dau_pkg::NA-1:0][31:0]  out_ts,
  output logic [dau_pkg::NA-1:0][31:0]  out_tc,
  output dau_pkg::side_t                out_side
);

  localparam logic [31:0] SDEN = dau_pkg::sin_den(STEP);
  localparam logic [31:0] CDEN = dau_pkg::cos_den(STEP);
  localparam logic [31:0] SDEN_NZ = (SDEN == 32'd0) ? 32'd1 : SDEN;
  localparam logic [63:0] SREC = (64'd1 << 32) / {32'd0, SDEN_NZ};
  localparam logic [63:0] CREC = (64'd1 << 32) / {32'd0, CDEN};
  localparam bit SBYP = (SDEN == 32'd0);

  logic [2:0]                      vld;
  logic [2:0][dau_pkg::NA-1:0][31:0] x2_d;
  dau_pkg::side_t [2:0]            side_d;

  // per polynomial (0 sine, 1 cosine), per lane
  logic [1:0][dau_pkg::NA-1:0][31:0] va, va_next;
  logic [1:0][dau_pkg::NA-1:0][31:0] vb, qb, qb_next;
  logic [1:0][dau_pkg::NA-1:0][31:0] tq, tq_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    x2_d   <= {x2_d[1:0], in_x2};
    side_d <= {side_d[1:0], in_side};
    va     <= va_next;
    vb     <= va;
    qb     <= qb_next;
    tq     <= tq_next;
  end

  always_comb begin
    logic [63:0] p;
    logic [63:0] q0d;
    logic [31:0] r;
    logic [31:0] q;
    for (int l = 0; l < dau_pkg::NA; l++) begin
      // stage A: x2 * t, Q31
      p = 64'(in_x2[l]) * 64'(in_ts[l]);
      va_next[0][l] = SBYP ? in_ts[l] : p[62:31];
      p = 64'(in_x2[l]) * 64'(in_tc[l]);
      va_next[1][l] = p[62:31];
      // stage B: reciprocal estimate, low by at most one
      p = 64'(va[0][l]) * SREC;
      qb_next[0][l] = p[63:32];
      p = 64'(va[1][l]) * CREC;
      qb_next[1][l] = p[63:32];
      // stage C: correct quotient, t = 1 - q
      q0d = 64'(qb[0][l]) * 64'(SDEN_NZ);
      r = vb[0][l] - q0d[31:0];
      q = (r >= SDEN_NZ) ? qb[0][l] + 32'd1 : qb[0][l];
      tq_next[0][l] = SBYP ? vb[0][l] : dau_pkg::Q31_ONE - q;
      q0d = 64'(qb[1][l]) * 64'(CDEN);
      r = vb[1][l] - q0d[31:0];
      q = (r >= CDEN) ? qb[1][l] + 32'd1 : qb[1][l];
      tq_next[1][l] = dau_pkg::Q31_ONE - q;
    end
  end

  assign out_vld  = vld[2];
  assign out_x2   = x2_d[2];
  assign out_side = side_d[2];
  assign out_ts   = tq[0];
  assign out_tc   = tq[1];

endmodule

[hw/rtl/dau_prod_cell.sv]
// One step of the component product chain: splits the running sine product on one angle.
module dau_prod_cell #(
  parameter int A = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_vld,
  input  dau_pkg::prod_t in_p,
  output logic           out_vld,
  output dau_pkg::prod_t out_p
);

  dau_pkg::prod_t p_next;

  always_comb begin
    p_next           = in_p;
    p_next.uv[A + 1] = dau_pkg::mulq(in_p.im, in_p.c[A]);
    p_next.im        = dau_pkg::mulq(in_p.im, in_p.s[A]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_p <= p_next;
  end

endmodule

[hw/rtl/dyadic_angles_to_unit_vector_unit.sv]
// Top level: dyadic interval ids to a unit vector in Q1.30.
//
// Command channel: a transaction is taken on each rising edge with start
// high and busy low; busy is low except during reset, so one set of ids
// can enter every cycle. The ids decode to angles, run through a row of
// seven Horner cells (sine and cosine series, three stages each) and then
// a row of DIM-1 product cells that build the components.
// done is registered with the result and is high for one cycle with it;
// throughput is one item per cycle, set by the fully pipelined cell rows.
// Results cannot be held off; a result is on the ports for its one cycle.
// Reset clears all valid bits (pending items are dropped) and sets
// dims_used to 4. dims_used sits at APB address 0; write it only while
// no item is in flight.
module dyadic_angles_to_unit_vector_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  dau_pkg::in_t  angles,
  output logic          done,
  output dau_pkg::res_t result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int NA  = dau_pkg::NA;
  localparam int LAT = 5 + 3 * dau_pkg::NSTEP + 2 + NA + 1;

  logic [2:0] dims_used;
  logic       accept;

  assign busy   = rst;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = {29'd0, dims_used};

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_used <= 3'd4;
    end else if (psel && penable && pwrite && (paddr[2] == dau_pkg::REG_DIMS_USED)) begin
      dims_used <= pwdata[2:0];
    end
  end

  // ---- stage 1: capture ids and clamped dimension count
  logic                   vld1;
  logic [NA-1:0][31:0]    id1;
  logic [2:0]             d1;
  logic [2:0]             dcl;

  assign dcl = (dims_used < 3'd2) ? 3'd2 :
               (dims_used > 3'(dau_pkg::DIM)) ? 3'(dau_pkg::DIM) : dims_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    id1[0] <= angles.angle_id_0;
    id1[1] <= angles.angle_id_1;
    id1[2] <= angles.angle_id_2;
    d1     <= dcl;
  end

  // ---- stage 2: classify ids, find leading one
  logic                        vld2, bad2;
  logic [NA-1:0][31:0]         id2;
  logic [NA-1:0][4:0]          k2;
  dau_pkg::lane_kind_t [NA-1:0] kind2;
  logic [NA-1:0][4:0]          k_next;
  dau_pkg::lane_kind_t [NA-1:0] kind_next;
  logic                        bad_next;

  always_comb begin
    logic used;
    bad_next = 1'b0;
    for (int a = 0; a < NA; a++) begin
      used = ((3'(a) + 3'd1) < d1);
      k_next[a] = 5'd0;
      for (int i = 0; i < 31; i++) begin
        if (id1[a][i]) begin
          k_next[a] = 5'(i);
        end
      end
      if (!used || (id1[a] == 32'd0)) begin
        kind_next[a] = dau_pkg::LK_SIN1;
      end else if (id1[a][31]) begin
        kind_next[a] = dau_pkg::LK_COS1;
        if (!(&id1[a])) begin
          bad_next = 1'b1;
        end
      end else begin
        kind_next[a] = dau_pkg::LK_NORM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    id2   <= id1;
    k2    <= k_next;
    kind2 <= kind_next;
    bad2  <= bad_next;
  end

  // ---- stage 3: phase = interval midpoint in Q0.32
  logic                        vld3, bad3;
  logic [NA-1:0][31:0]         ph3, ph_next;
  dau_pkg::lane_kind_t [NA-1:0] kind3;

  always_comb begin
    logic [32:0] w;
    logic [32:0] wsh;
    for (int a = 0; a < NA; a++) begin
      w   = {id2[a], 1'b1} & ~(33'd1 << ({1'b0, k2[a]} + 6'd1));
      wsh = w << (6'd31 - {1'b0, k2[a]});
      ph_next[a] = wsh[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    ph3   <= ph_next;
    kind3 <= kind2;
    bad3  <= bad2;
  end

  // ---- stage 4: fold above one half, angle x in Q31
  logic                        vld4, bad4;
  logic [NA-1:0][31:0]         x4, x_next;
  logic [NA-1:0]               swap4, swap_next;
  dau_pkg::lane_kind_t [NA-1:0] kind4;

  always_comb begin
    logic [32:0] gd;
    logic [63:0] p;
    for (int a = 0; a < NA; a++) begin
      swap_next[a] = (ph3[a] > dau_pkg::Q31_ONE);
      gd = swap_next[a] ? (33'h1_0000_0000 - {1'b0, ph3[a]}) : {1'b0, ph3[a]};
      p  = 64'(gd[31:0]) * 64'(dau_pkg::PIHALF_Q31);
      x_next[a] = p[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    x4    <= x_next;
    swap4 <= swap_next;
    kind4 <= kind3;
    bad4  <= bad3;
  end

  // ---- stage 5: x squared
  logic                 vld5;
  logic [NA-1:0][31:0]  x2_5, x2_next;
  dau_pkg::side_t       side5;
  logic [NA-1:0][31:0]  t_init;

  always_comb begin
    logic [63:0] p;
    for (int a = 0; a < NA; a++) begin
      p = 64'(x4[a]) * 64'(x4[a]);
      x2_next[a] = p[62:31];
      t_init[a]  = dau_pkg::Q31_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld5 <= 1'b0;
    end else begin
      vld5 <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    x2_5       <= x2_next;
    side5.x    <= x4;
    side5.swap <= swap4;
    side5.kind <= kind4;
    side5.bad  <= bad4;
  end

  // ---- Horner cell row
  logic [dau_pkg::NSTEP:0]                      hv;
  logic [dau_pkg::NSTEP:0][NA-1:0][31:0]        hx2, hts, htc;
  dau_pkg::side_t [dau_pkg::NSTEP:0]            hside;

  assign hv[0]    = vld5;
  assign hx2[0]   = x2_5;
  assign hts[0]   = t_init;
  assign htc[0]   = t_init;
  assign hside[0] = side5;

  for (genvar g = 0; g < dau_pkg::NSTEP; g++) begin : g_horner
    dau_horner_cell #(.STEP(g)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (hv[g]),
      .in_x2    (hx2[g]),
      .in_ts    (hts[g]),
      .in_tc    (htc[g]),
      .in_side  (hside[g]),
      .out_vld  (hv[g + 1]),
      .out_x2   (hx2[g + 1]),
      .out_ts   (hts[g + 1]),
      .out_tc   (htc[g + 1]),
      .out_side (hside[g + 1])
    );
  end

  // ---- sine = x * t, cosine = t (Q31)
  logic                 vld6;
  logic [NA-1:0][31:0]  s6, c6, s_next;
  dau_pkg::side_t       side6;

  always_comb begin
    logic [63:0] p;
    for (int a = 0; a < NA; a++) begin
      p = 64'(hside[dau_pkg::NSTEP].x[a]) * 64'(hts[dau_pkg::NSTEP][a]);
      s_next[a] = p[62:31];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld6 <= 1'b0;
    end else begin
      vld6 <= hv[dau_pkg::NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    s6    <= s_next;
    c6    <= htc[dau_pkg::NSTEP];
    side6 <= hside[dau_pkg::NSTEP];
  end

  // ---- unswap, round to Q1.30, apply edge and unused-angle values
  function automatic logic [30:0] to_q(input logic [31:0] v);
    logic [32:0] r;
    r = ({1'b0, v} + 33'd1) >> 1;
    return (r > 33'(dau_pkg::Q_ONE)) ? dau_pkg::Q_ONE : r[30:0];
  endfunction

  logic           vld7;
  dau_pkg::prod_t p7, p7_next;

  always_comb begin
    logic [31:0] sv;
    logic [31:0] cv;
    p7_next     = '0;
    p7_next.im  = dau_pkg::Q_ONE;
    p7_next.bad = side6.bad;
    for (int a = 0; a < NA; a++) begin
      sv = side6.swap[a] ? c6[a] : s6[a];
      cv = side6.swap[a] ? s6[a] : c6[a];
      case (side6.kind[a])
        dau_pkg::LK_SIN1: begin
          p7_next.s[a] = dau_pkg::Q_ONE;
          p7_next.c[a] = 31'd0;
        end
        dau_pkg::LK_COS1: begin
          p7_next.s[a] = 31'd0;
          p7_next.c[a] = dau_pkg::Q_ONE;
        end
        default: begin
          p7_next.s[a] = to_q(sv);
          p7_next.c[a] = to_q(cv);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld7 <= 1'b0;
    end else begin
      vld7 <= vld6;
    end
  end

  always_ff @(posedge clk) begin
    p7 <= p7_next;
  end

  // ---- product cell row, top angle first
  logic [NA:0]            pv;
  dau_pkg::prod_t [NA:0]  pp;

  assign pv[0] = vld7;
  assign pp[0] = p7;

  for (genvar j = 0; j < NA; j++) begin : g_prod
    dau_prod_cell #(.A(NA - 1 - j)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (pv[j]),
      .in_p    (pp[j]),
      .out_vld (pv[j + 1]),
      .out_p   (pp[j + 1])
    );
  end

  // ---- output register
  dau_pkg::res_t res_next;

  always_comb begin
    res_next        = '0;
    res_next.bad_id = pp[NA].bad;
    if (!pp[NA].bad) begin
      res_next.uv_0 = pp[NA].im;
      res_next.uv_1 = pp[NA].uv[1];
      res_next.uv_2 = pp[NA].uv[2];
      res_next.uv_3 = pp[NA].uv[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pv[NA];
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

`ifndef SYNTH
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.bad_id |-> (result.uv_0 == 31'd0) && (result.uv_1 == 31'd0) &&
                              (result.uv_2 == 31'd0) && (result.uv_3 == 31'd0))
    else $error("bad id result carries nonzero components");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a start transaction at the pipeline latency");

  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.uv_0 <= dau_pkg::Q_ONE) && (result.uv_1 <= dau_pkg::Q_ONE) &&
             (result.uv_2 <= dau_pkg::Q_ONE) && (result.uv_3 <= dau_pkg::Q_ONE))
    else $error("component above one");
`endif

endmodule

[test/tb_top.sv]
// Testbench for dyadic_angles_to_unit_vector_unit: directed table plus random ids, checked
// against a local predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 40;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 143;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  dau_pkg::in_t angles = '0;
  logic done;
  dau_pkg::res_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dau_pkg::res_t pending_vectors[$];
  int errors = 0;
  int stall_cycles = 0;
  logic [2:0] dims_reg = 3'd4;

  dyadic_angles_to_unit_vector_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .angles(angles),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  // sin/cos of a quarter-turn fraction (Q0.32), both in Q31
  function automatic void quarter_turn_sincos(input bit [63:0] phase,
                                              output bit [63:0] s, output bit [63:0] c);
    bit [63:0] sden [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};
    bit [63:0] cden [7] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182};
    bit [63:0] x, x2, t, tmp;
    bit swap;
    swap = 1'b0;
    if (phase > 64'h8000_0000) begin
      phase = 64'h1_0000_0000 - phase;
      swap = 1'b1;
    end
    x = (phase * 64'(dau_pkg::PIHALF_Q31)) >> 32;
    x2 = (x * x) >> 31;
    t = 64'(dau_pkg::Q31_ONE);
    for (int i = 5; i >= 0; i--) t = 64'(dau_pkg::Q31_ONE) - ((x2 * t) >> 31) / sden[i];
    s = (x * t) >> 31;
    t = 64'(dau_pkg::Q31_ONE);
    for (int i = 6; i >= 0; i--) t = 64'(dau_pkg::Q31_ONE) - ((x2 * t) >> 31) / cden[i];
    c = t;
    if (swap) begin
      tmp = s;
      s = c;
      c = tmp;
    end
  endfunction

  function automatic bit [63:0] q31_to_q30(input bit [63:0] v);
    bit [63:0] r;
    r = (v + 1) >> 1;
    return (r > 64'(dau_pkg::Q_ONE)) ? 64'(dau_pkg::Q_ONE) : r;
  endfunction

  function automatic bit [63:0] qmul(input bit [63:0] a, input bit [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // returns 0 for an invalid id
  function automatic bit id_sincos(input logic signed [31:0] id,
                                   output bit [63:0] s, output bit [63:0] c);
    bit [63:0] v, n, phase, s31, c31;
    int k;
    v = 64'(unsigned'(id));
    if (id < 0) begin
      s = 0;
      c = 64'(dau_pkg::Q_ONE);
      return (id == -1);
    end
    if (v == 0) begin
      s = 64'(dau_pkg::Q_ONE);
      c = 0;
      return 1'b1;
    end
    k = 30;
    while (v[k] == 1'b0) k--;
    n = 2 * (v - (64'd1 << k)) + 1;
    phase = n << (31 - k);
    quarter_turn_sincos(phase, s31, c31);
    s = q31_to_q30(s31);
    c = q31_to_q30(c31);
    return 1'b1;
  endfunction

  function automatic dau_pkg::res_t unit_vector_of(input dau_pkg::in_t ids,
                                                   input logic [2:0] dims);
    logic signed [31:0] id_arr [dau_pkg::NA];
    bit [63:0] sn [dau_pkg::NA];
    bit [63:0] cs [dau_pkg::NA];
    bit [63:0] uv [dau_pkg::DIM];
    bit [63:0] im;
    int d;
    bit bad;
    dau_pkg::res_t r;
    id_arr[0] = ids.angle_id_0;
    id_arr[1] = ids.angle_id_1;
    id_arr[2] = ids.angle_id_2;
    d = (dims < 2) ? 2 : ((dims > dau_pkg::DIM) ? dau_pkg::DIM : int'(dims));
    bad = 1'b0;
    for (int i = 0; i < dau_pkg::NA; i++) begin
      sn[i] = 0;
      cs[i] = 0;
    end
    for (int i = 0; i < d - 1; i++)
      if (!id_sincos(id_arr[i], sn[i], cs[i])) bad = 1'b1;
    for (int i = 0; i < dau_pkg::DIM; i++) uv[i] = 0;
    if (!bad) begin
      im = 64'(dau_pkg::Q_ONE);
      for (int i = d - 1; i > 0; i--) begin
        uv[i] = qmul(im, cs[i-1]);
        im = qmul(im, sn[i-1]);
      end
      uv[0] = im;
    end
    r.uv_0 = uv[0][30:0];
    r.uv_1 = uv[1][30:0];
    r.uv_2 = uv[2][30:0];
    r.uv_3 = uv[3][30:0];
    r.bad_id = bad;
    return r;
  endfunction

  function automatic logic signed [31:0] random_id();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return -1;
    if (pick < 18) return 0;
    if (pick < 22) return $signed($urandom() | 32'h8000_0000);
    if (pick < 45) return $urandom_range(1, 255);
    if (pick < 55) return $urandom();
    return $urandom() & 32'h7FFF_FFFF;
  endfunction

  // one command transaction; typed expectation used when given
  task automatic send_ids(input dau_pkg::in_t ids, input int gap, input bit typed,
                          input dau_pkg::res_t typed_res);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    angles <= ids;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_vectors = {pending_vectors, (typed ? typed_res : unit_vector_of(ids, dims_reg))};
  endtask

  task automatic write_dims(input logic [2:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(dau_pkg::REG_DIMS_USED) << 2;
    pwdata <= {$urandom_range(0, 1) ? $urandom() : 32'd0} & 32'hFFFF_FFF8 | 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dims_reg = value;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_vectors.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_vectors.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
        errors++;
      end else begin
        dau_pkg::res_t want;
        want = pending_vectors.pop_front();
        if (want.uv_0 !== result.uv_0) begin
          $display("%0t: uv_0 expected %h actual %h", $time, want.uv_0, result.uv_0);
          errors++;
        end
        if (want.uv_1 !== result.uv_1) begin
          $display("%0t: uv_1 expected %h actual %h", $time, want.uv_1, result.uv_1);
          errors++;
        end
        if (want.uv_2 !== result.uv_2) begin
          $display("%0t: uv_2 expected %h actual %h", $time, want.uv_2, result.uv_2);
          errors++;
        end
        if (want.uv_3 !== result.uv_3) begin
          $display("%0t: uv_3 expected %h actual %h", $time, want.uv_3, result.uv_3);
          errors++;
        end
        if (want.bad_id !== result.bad_id) begin
          $display("%0t: bad_id expected %b actual %b", $time, want.bad_id, result.bad_id);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  typedef struct {
    dau_pkg::in_t ids;
    bit typed;
    dau_pkg::res_t res;
  } stim_row_t;

  localparam dau_pkg::res_t ALL_ZERO = '0;
  localparam dau_pkg::res_t BAD = '{bad_id: 1'b1, default: '0};
  localparam dau_pkg::res_t LEFT_EDGE = '{uv_3: dau_pkg::Q_ONE, default: '0};
  localparam dau_pkg::res_t RIGHT_EDGE = '{uv_0: dau_pkg::Q_ONE, default: '0};

  stim_row_t dir_table [] = '{
    '{'{-32'sd1, -32'sd1, -32'sd1}, 1'b1, LEFT_EDGE},
    '{'{32'sd0, 32'sd0, 32'sd0}, 1'b1, RIGHT_EDGE},
    '{'{32'sd0, 32'sd0, -32'sd2}, 1'b1, BAD},
    '{'{32'sh8000_0000, 32'sd0, 32'sd0}, 1'b1, BAD},
    '{'{32'sd5, -32'sd7, 32'sd9}, 1'b1, BAD},
    '{'{32'shFFFF_FFFE, 32'sd1, 32'sd1}, 1'b1, BAD},
    '{'{32'sd1, 32'sd1, 32'sd1}, 1'b0, ALL_ZERO},
    '{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}, 1'b0, ALL_ZERO},
    '{'{32'sh4000_0000, 32'sd2, 32'sd3}, 1'b0, ALL_ZERO},
    '{'{32'sh5555_5555, 32'sh2AAA_AAAA, 32'sd4}, 1'b0, ALL_ZERO},
    '{'{32'sd0, -32'sd1, 32'sd1}, 1'b0, ALL_ZERO},
    '{'{-32'sd1, 32'sd0, 32'sd6}, 1'b0, ALL_ZERO},
    '{'{32'sd7, 32'sd255, 32'sd128}, 1'b0, ALL_ZERO},
    '{'{32'sh4000_0001, 32'sh7FFF_FFFE, 32'sh0001_0000}, 1'b0, ALL_ZERO},
    '{'{32'sd3, 32'sd0, -32'sd1}, 1'b0, ALL_ZERO}
  };

  logic [2:0] dims_plan [] = '{3'd2, 3'd0, 3'd3, 3'd7, 3'd1, 3'd4, 3'd5, 3'd6, 3'd4};

  initial begin
    dau_pkg::in_t ids;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_table[i])
      send_ids(dir_table[i].ids, $urandom_range(0, 3), dir_table[i].typed, dir_table[i].res);
    drain();
    foreach (dims_plan[p]) begin
      bit busy_phase;
      write_dims(dims_plan[p]);
      busy_phase = $urandom_range(0, 2) == 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        ids.angle_id_0 = random_id();
        ids.angle_id_1 = random_id();
        ids.angle_id_2 = random_id();
        send_ids(ids, busy_phase ? 0 : $urandom_range(0, 13), 1'b0, ALL_ZERO);
      end
      drain();
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
